[rtl/core/positional_list_engine_defines.svh]
// Assertion macros used by the port checker file of the positional list engine.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine check failed");

// Next-cycle implication, held off during reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine check failed");

`endif

[rtl/core/ple_pkg.sv]
// Shared types and constants of the positional list engine.
// Used by the cell, the controller, the top level and the checker.
package ple_pkg;

    localparam int DEPTH  = 16;
    localparam int REQ_W  = 3;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    localparam int IN_FIELDS_W  = REQ_W + POS_W + VAL_W;
    localparam int OUT_FIELDS_W = STAT_W + VAL_W + SIZE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_HEAD = 3'd0,
        REQ_ADD_TAIL = 3'd1,
        REQ_INSERT   = 3'd2,
        REQ_DEL_HEAD = 3'd3,
        REQ_DEL_TAIL = 3'd4,
        REQ_DEL_AT   = 3'd5,
        REQ_READ_AT  = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_OPEN,
        CELL_CLOSE,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [IDX_W-1:0]        pos;
        logic [IDX_W-1:0]        rd_pos;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

[rtl/core/ple_cell.sv]
// One element slot of the list chain: holds a value and trades it with its neighbors.
// Depends on ple_pkg for the command struct.
module ple_cell
    import ple_pkg::*;
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        idx,
    input  cell_cmd_t               cmd,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    output logic signed [VAL_W-1:0] data,
    output logic signed [VAL_W-1:0] tap
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_OPEN:
            begin
                // slots above the opening take the word from below
                if (idx > cmd.pos)
                    data_next = left_data;
                else if (idx == cmd.pos)
                    data_next = cmd.value;
            end
            CELL_CLOSE:
            begin
                if (idx >= cmd.pos)
                    data_next = right_data;
            end
            CELL_WRITE:
            begin
                if (idx == cmd.pos)
                    data_next = cmd.value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (idx == cmd.rd_pos) ? data_reg : '0;

endmodule

[rtl/core/ple_ctrl.sv]
// Request decoder, element counter and result register of the positional list engine.
// Depends on ple_pkg; drives the command broadcast to the cell chain.
module ple_ctrl
    import ple_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] item_value,
    input  logic signed [VAL_W-1:0] rd_data,
    output cell_cmd_t               cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0] read_value,
    output logic [SIZE_W-1:0]       list_size
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STAT_W-1:0]       status_reg;
    logic signed [VAL_W-1:0] read_value_reg;
    logic [SIZE_W-1:0]       list_size_reg;

    logic                    accept;
    logic [IDX_W-1:0]        cnt_ext;
    logic [IDX_W-1:0]        pos_ext;
    logic [IDX_W-1:0]        size_ext;
    logic                    full;
    logic                    empty;
    logic                    in_range;
    status_t                 status_c;
    logic signed [VAL_W-1:0] rd_c;
    logic [CNT_W-1:0]        count_c;
    cell_cmd_t               cmd_c;

    // take a new word while the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cnt_ext  = IDX_W'(count_reg);
    assign pos_ext  = IDX_W'(position);
    assign full     = (cnt_ext == IDX_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign in_range = (pos_ext < cnt_ext);

    always_comb
    begin
        status_c     = ST_OK;
        rd_c         = '0;
        count_c      = count_reg;
        cmd_c.op     = CELL_HOLD;
        cmd_c.pos    = '0;
        cmd_c.rd_pos = pos_ext;
        cmd_c.value  = item_value;
        case (req_type)
            REQ_ADD_HEAD:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    cmd_c.op = CELL_OPEN;
                    count_c  = count_reg + CNT_W'(1);
                end
            end
            REQ_ADD_TAIL:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    cmd_c.op  = CELL_WRITE;
                    cmd_c.pos = cnt_ext;
                    count_c   = count_reg + CNT_W'(1);
                end
            end
            REQ_INSERT:
            begin
                if (!in_range)
                    status_c = ST_RANGE;
                else if (full)
                    status_c = ST_FULL;
                else
                begin
                    cmd_c.op  = CELL_OPEN;
                    cmd_c.pos = pos_ext;
                    count_c   = count_reg + CNT_W'(1);
                end
            end
            REQ_DEL_HEAD:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else
                begin
                    cmd_c.op = CELL_CLOSE;
                    count_c  = count_reg - CNT_W'(1);
                end
            end
            REQ_DEL_TAIL:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else
                    count_c = count_reg - CNT_W'(1);
            end
            REQ_DEL_AT:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else if (!in_range)
                    status_c = ST_RANGE;
                else
                begin
                    cmd_c.op  = CELL_CLOSE;
                    cmd_c.pos = pos_ext;
                    count_c   = count_reg - CNT_W'(1);
                end
            end
            REQ_READ_AT:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else if (!in_range)
                    status_c = ST_RANGE;
                else
                    rd_c = rd_data;
            end
            default:
            begin
                status_c = ST_RANGE;
            end
        endcase
        // cells move only on an accepted word
        if (!accept)
            cmd_c.op = CELL_HOLD;
    end

    assign cmd        = cmd_c;
    assign count_next = accept ? count_c : count_reg;
    assign size_ext   = IDX_W'(count_c);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_c;
            read_value_reg <= rd_c;
            list_size_reg  <= size_ext[SIZE_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign list_size  = list_size_reg;

endmodule

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: stream ports, controller and cell chain.
// Depends on ple_pkg, ple_cell and ple_ctrl.
//
// The engine keeps an ordered list of up to DEPTH signed 32-bit words in a row
// of cells, one word per cell, and answers every request word with exactly one
// result word. When a request is taken, all cells shift, load or hold together
// at that edge, and the result appears in the output register on the
// next cycle. The input is ready whenever the output register is empty or is
// being drained in the same cycle, so the engine sustains one request per
// cycle while the output side keeps up; the single output register is what
// sets that figure. Reads select the addressed cell through an OR tree over
// the cell taps. No clearing pass runs after reset; the list starts empty.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] req_type, [6:3] position, [38:7] item_value, [39] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] status, [33:2] read_value, [38:34] list_size, [39] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cell_cmd_t               cmd;
    logic signed [VAL_W-1:0] cell_data [DEPTH];
    logic signed [VAL_W-1:0] cell_tap  [DEPTH];
    logic signed [VAL_W-1:0] rd_data;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [SIZE_W-1:0]       list_size;

    ple_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_type   (s_axis_tdata[REQ_W-1:0]),
        .position   (s_axis_tdata[REQ_W+POS_W-1:REQ_W]),
        .item_value (s_axis_tdata[IN_FIELDS_W-1:REQ_W+POS_W]),
        .rd_data    (rd_data),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (status),
        .read_value (read_value),
        .list_size  (list_size)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_data;
        logic signed [VAL_W-1:0] right_data;

        if (i == 0)
        begin : g_head
            assign left_data = cmd.value;
        end
        else
        begin : g_body
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner
            assign right_data = cell_data[i+1];
        end

        ple_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_data = rd_data | cell_tap[i];
    end

    assign m_axis_tdata = {
        {(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
        list_size,
        read_value,
        status
    };

endmodule

[rtl/core/ple_checker.sv]
// Port-level checks of the positional list engine, bound to the top level.
// Depends on ple_pkg and the assertion macros in positional_list_engine_defines.svh.
`include "positional_list_engine_defines.svh"

module ple_port_checks
    import ple_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(DEPTH);

    logic [STAT_W-1:0]       out_status;
    logic signed [VAL_W-1:0] out_read_value;
    logic [SIZE_W-1:0]       out_size;

    assign out_status     = m_axis_tdata[STAT_W-1:0];
    assign out_read_value = m_axis_tdata[STAT_W+VAL_W-1:STAT_W];
    assign out_size       = m_axis_tdata[OUT_FIELDS_W-1:STAT_W+VAL_W];

    `PLE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `PLE_ASSERT_NOW(a_full_size, clk, rst_n, m_axis_tvalid && out_status == ST_FULL,
        out_size == FULL_SIZE)
    `PLE_ASSERT_NOW(a_empty_size, clk, rst_n, m_axis_tvalid && out_status == ST_EMPTY,
        out_size == '0)
    `PLE_ASSERT_NOW(a_read_ok, clk, rst_n, m_axis_tvalid && out_read_value != '0,
        out_status == ST_OK && out_size != '0)

endmodule

bind positional_list_engine ple_port_checks u_ple_port_checks (.*);

[sim/ple_checker.sv]
// Request/reply checker for the positional list engine: watches both streams,
// keeps a shadow list and compares every reply word. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_checker
    import ple_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    errors,
    output int                    pending,
    output int                    list_len,
    output int                    checked,
    output int                    range_hits,
    output int                    full_hits,
    output int                    empty_hits
);

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] read_value;
        logic [SIZE_W-1:0]       list_size;
    } list_reply_t;

    logic signed [VAL_W-1:0] shadow_list [DEPTH];
    int                      shadow_len;
    list_reply_t             replies_due [$];
    list_reply_t             want;
    list_reply_t             got;

    // Apply one request to the shadow list and return the reply it should give.
    function automatic list_reply_t apply_list_request(input logic [REQ_W-1:0] req,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic signed [VAL_W-1:0] val);
        list_reply_t reply;
        logic        full;
        logic        empty;
        int          p;
        int          i;
        full  = shadow_len >= DEPTH;
        empty = shadow_len == 0;
        p     = int'(pos);
        reply.status     = ST_OK;
        reply.read_value = '0;
        case (req)
            REQ_ADD_HEAD, REQ_ADD_TAIL, REQ_INSERT:
            begin
                if (req == REQ_INSERT && p >= shadow_len)
                    reply.status = ST_RANGE;
                else if (full)
                    reply.status = ST_FULL;
                else
                begin
                    if (req == REQ_ADD_HEAD)
                        p = 0;
                    else if (req == REQ_ADD_TAIL)
                        p = shadow_len;
                    // open a slot at p
                    for (i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = val;
                    shadow_len++;
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_AT, REQ_READ_AT:
            begin
                if (req == REQ_DEL_HEAD)
                    p = 0;
                else if (req == REQ_DEL_TAIL)
                    p = shadow_len - 1;
                if (empty)
                    reply.status = ST_EMPTY;
                else if (p >= shadow_len)
                    reply.status = ST_RANGE;
                else if (req == REQ_READ_AT)
                    reply.read_value = shadow_list[p];
                else
                begin
                    // close the slot at p
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            default:
                reply.status = ST_RANGE;
        endcase
        reply.list_size = shadow_len[SIZE_W-1:0];
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replies_due.delete();
            for (int k = 0; k < DEPTH; k++)
                shadow_list[k] = '0;
            shadow_len = 0;
            errors     <= 0;
            pending    <= 0;
            list_len   <= 0;
            checked    <= 0;
            range_hits <= 0;
            full_hits  <= 0;
            empty_hits <= 0;
        end
        else
        begin
            // the reply leaving now always belongs to an earlier request
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status     = status_t'(m_axis_tdata[STAT_W-1:0]);
                got.read_value = m_axis_tdata[STAT_W +: VAL_W];
                got.list_size  = m_axis_tdata[STAT_W+VAL_W +: SIZE_W];
                if (replies_due.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: reply word with none due: status %0d value %0d size %0d",
                             $time, got.status, got.read_value, got.list_size);
                end
                else
                begin
                    want = replies_due.pop_front();
                    checked <= checked + 1;
                    if (want.status == ST_RANGE)
                        range_hits <= range_hits + 1;
                    if (want.status == ST_FULL)
                        full_hits <= full_hits + 1;
                    if (want.status == ST_EMPTY)
                        empty_hits <= empty_hits + 1;
                    if (got.status != want.status || got.read_value != want.read_value
                        || got.list_size != want.list_size)
                    begin
                        errors <= errors + 1;
                        $display("%0t: mismatch: expected status %0d value %0d size %0d, got status %0d value %0d size %0d",
                                 $time, want.status, want.read_value, want.list_size,
                                 got.status, got.read_value, got.list_size);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(apply_list_request(
                    s_axis_tdata[REQ_W-1:0],
                    s_axis_tdata[REQ_W +: POS_W],
                    s_axis_tdata[REQ_W+POS_W +: VAL_W]));
            pending  <= replies_due.size();
            list_len <= shadow_len;
        end
    end

endmodule

[sim/tb.sv]
// Testbench top of the positional list engine: clock, reset, request traffic,
// reply back-pressure and verdict. Depends on ple_pkg, ple_checker and the engine.
`timescale 1ns / 1ps

module tb;
    import ple_pkg::*;

    localparam int               CLK_PERIOD      = 8;
    localparam int               RANDOM_ITEMS    = 1800;
    localparam int               STALL_LIMIT     = 2000;
    localparam int               HOLD_OFF_CYCLES = 300;
    localparam int               SETTLE_CYCLES   = 10;
    localparam logic [REQ_W-1:0] REQ_UNDEFINED   = 3'd7;

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int errors;
    int pending;
    int list_len;
    int checked;
    int range_hits;
    int full_hits;
    int empty_hits;
    int sent       = 0;
    int burst_left = 0;

    positional_list_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ple_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .list_len      (list_len),
        .checked       (checked),
        .range_hits    (range_hits),
        .full_hits     (full_hits),
        .empty_hits    (empty_hits)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offer one request word and hold it until the engine takes it.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, val, pos, req};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // Stop offering and wait until every reply due has come back.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [REQ_W-1:0] pick_request(input traffic_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return REQ_UNDEFINED;
        case (mode)
            MODE_GROW:
                if (r < 30)      return REQ_ADD_TAIL;
                else if (r < 50) return REQ_ADD_HEAD;
                else if (r < 75) return REQ_INSERT;
                else if (r < 85) return REQ_READ_AT;
                else if (r < 90) return REQ_DEL_HEAD;
                else if (r < 95) return REQ_DEL_TAIL;
                else             return REQ_DEL_AT;
            MODE_SHRINK:
                if (r < 25)      return REQ_DEL_HEAD;
                else if (r < 50) return REQ_DEL_TAIL;
                else if (r < 75) return REQ_DEL_AT;
                else if (r < 85) return REQ_READ_AT;
                else if (r < 90) return REQ_ADD_HEAD;
                else if (r < 95) return REQ_ADD_TAIL;
                else             return REQ_INSERT;
            default:
                return REQ_W'($urandom_range(0, 6));
        endcase
    endfunction

    // Mostly valid positions, some just past the end, some anywhere.
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2 || list_len == 0)
            return POS_W'($urandom_range(0, 15));
        if (r == 2)
            return (list_len > 15) ? POS_W'(15) : POS_W'(list_len);
        return POS_W'($urandom_range(0, list_len - 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        traffic_mode_t mode;
        int            mode_left;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every delete and read, insert and unknown request
        send_request(REQ_DEL_HEAD, 4'd0, '0);
        send_request(REQ_DEL_TAIL, 4'd15, '1);
        send_request(REQ_DEL_AT, 4'd0, '0);
        send_request(REQ_READ_AT, 4'd0, '0);
        send_request(REQ_INSERT, 4'd0, 32'h1234_5678);
        send_request(REQ_UNDEFINED, 4'd15, '1);
        // build, insert one before the tail, read back and range-check
        send_request(REQ_ADD_TAIL, 4'd0, 32'h7fff_ffff);
        send_request(REQ_ADD_HEAD, 4'd15, 32'h8000_0000);
        send_request(REQ_INSERT, 4'd1, '0);
        send_request(REQ_READ_AT, 4'd0, '0);
        send_request(REQ_READ_AT, 4'd2, '0);
        send_request(REQ_READ_AT, 4'd3, '0);
        send_request(REQ_READ_AT, 4'd15, '0);
        send_request(REQ_INSERT, 4'd15, 32'h5555_aaaa);
        send_request(REQ_DEL_AT, 4'd0, '0);
        send_request(REQ_DEL_AT, 4'd2, '0);
        send_request(REQ_ADD_HEAD, 4'd0, '1);
        send_request(REQ_DEL_AT, 4'd1, '0);
        send_request(REQ_DEL_TAIL, 4'd0, '0);
        send_request(REQ_DEL_HEAD, 4'd0, '0);
        drain_replies();

        // random traffic in phases; start by filling the list
        mode      = MODE_GROW;
        mode_left = 40;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mode_left == 0)
            begin
                mode      = traffic_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (n == RANDOM_ITEMS / 2)
                drain_replies();
            send_request(pick_request(mode), pick_position(), pick_value());
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d requests over phases of growth, shrinkage and mixed traffic.", sent);
        $display("Checked %0d replies: %0d out of range, %0d full, %0d empty.",
                 checked, range_hits, full_hits, empty_hits);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Reply side: segments of steady, light and heavy stalling, one long hold-off.
    initial
    begin : receiver
        int seg;
        int seg_len;
        int kind;
        seg = 0;
        wait (rst_n);
        forever
        begin
            seg++;
            if (seg == 4)
            begin
                @(posedge clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                kind    = $urandom_range(0, 3);
                seg_len = $urandom_range(10, 120);
                repeat (seg_len)
                begin
                    @(posedge clk);
                    case (kind)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= $urandom_range(0, 1);
                        2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine.sv
rtl/core/ple_checker.sv
sim/ple_checker.sv
sim/tb.sv
